// File: sv/mpsa_pkg.sv
// ----------------------------------------------------------------------------
// Multi-pool slot allocator package
// Shared types, command and status codes, and the capacity rule of a pool.
// ----------------------------------------------------------------------------
package mpsa_pkg;

   localparam int SLOT_W  = 8;
   localparam int POOL_W  = 4;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 9;
   localparam int MASK_W  = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOT_USED = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [1:0] CSR_SINGLE_MASK = 2'd1;
   localparam logic [1:0] CSR_FRONT_MASK  = 2'd2;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 9'd256;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POOL_W-1:0] pool;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot_out;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pool_capacity;
      logic [MASK_W-1:0]  single_slot_mask;
      logic [MASK_W-1:0]  free_to_front_mask;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [POOL_W-1:0]  pool;
      logic [SLOT_W-1:0]  slot;
      logic               pool_ok;
      logic               slot_ok;
      logic               to_front;
      logic [COUNT_W-1:0] cap;
   } entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   function automatic logic [COUNT_W-1:0] cap_of(
      input logic [COUNT_W-1:0] capacity,
      input logic               single,
      input logic [COUNT_W-1:0] limit
   );
      logic [COUNT_W-1:0] c;
      c = capacity;
      if (c == '0) begin
         c = 9'd1;
      end
      if (c > limit) begin
         c = limit;
      end
      if (single) begin
         c = 9'd1;
      end
      return c;
   endfunction

endpackage

// File: sv/mpsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/mpsa_front.sv
// ----------------------------------------------------------------------------
// Allocator front end
// Classifies each accepted item against the pool configuration and holds it
// in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module mpsa_front #(
   parameter int NUM_POOLS = 16,
   parameter int LIM       = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mpsa_pkg::req_type   req,
   input  mpsa_pkg::cfg_type   cfg,
   input  logic                pop,
   output logic                q_valid,
   output logic                q_full,
   output mpsa_pkg::entry_type q_head
);

   mpsa_pkg::entry_type entry;
   mpsa_pkg::entry_type q_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      entry.cmd      = req.cmd;
      entry.pool     = req.pool;
      entry.slot     = req.slot;
      entry.pool_ok  = (32'(req.pool) < NUM_POOLS);
      entry.to_front = cfg.free_to_front_mask[req.pool];
      entry.cap      = mpsa_pkg::cap_of(cfg.pool_capacity, cfg.single_slot_mask[req.pool],
                                        mpsa_pkg::COUNT_W'(LIM));
      entry.slot_ok  = ({1'b0, req.slot} < entry.cap);
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_head  = q_ff[rd_ptr_ff];

endmodule

// File: sv/mpsa_back.sv
// ----------------------------------------------------------------------------
// Allocator back end
// Runs the clearing pass, then carries out queued items: a RAM read in the
// idle state and an update in the exec state per item, with the result registered.
// ----------------------------------------------------------------------------
module mpsa_back #(
   parameter int NUM_POOLS = 16,
   parameter int LIM       = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                reinit,
   input  mpsa_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  mpsa_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   output mpsa_pkg::rsp_type   rsp_data
);

   localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int LW    = (LIM > 1) ? $clog2(LIM) : 1;
   localparam int AW    = PW + LW;
   localparam int DEPTH = NUM_POOLS * (2 ** LW);
   localparam int SW    = mpsa_pkg::SLOT_W;
   localparam int CW    = mpsa_pkg::COUNT_W;

   mpsa_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   mpsa_pkg::entry_type      cur_ff;
   logic [SW-1:0]            cur_head_ff;
   logic [CW-1:0]            cur_cnt_ff;
   logic [SW-1:0]            head_ff [NUM_POOLS];
   logic [CW-1:0]            cnt_ff [NUM_POOLS];
   logic                     rsp_valid_ff;
   mpsa_pkg::rsp_type        rsp_ff, rsp_in;

   logic [PW-1:0] qidx, cidx;
   logic [AW-1:0] ring_raddr, use_raddr, ring_waddr, use_waddr;
   logic [SW-1:0] ring_rdata, ring_wdata;
   logic          use_rdata, use_wdata, ring_we, use_we;
   logic          upd;
   logic [SW-1:0] head_new, pos;
   logic [CW-1:0] cnt_new, sum;

   assign qidx = q_head.pool_ok ? q_head.pool[PW-1:0] : '0;
   assign cidx = cur_ff.pool_ok ? cur_ff.pool[PW-1:0] : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpsa_pkg::BK_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = mpsa_pkg::BK_IDLE;
            end
         end
         mpsa_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = mpsa_pkg::BK_EXEC;
            end
         end
         mpsa_pkg::BK_EXEC: begin
            state_in = mpsa_pkg::BK_IDLE;
         end
         default: begin
            state_in = mpsa_pkg::BK_CLEAR;
         end
      endcase
      if (reinit) begin
         state_in = mpsa_pkg::BK_CLEAR;
      end
   end

   always_comb begin
      q_pop      = 1'b0;
      clearing   = 1'b0;
      clr_in     = '0;
      ring_raddr = {qidx, head_ff[qidx][LW-1:0]};
      use_raddr  = {qidx, q_head.slot[LW-1:0]};
      ring_we    = 1'b0;
      ring_waddr = clr_ff;
      ring_wdata = SW'(clr_ff[LW-1:0]);
      use_we     = 1'b0;
      use_waddr  = clr_ff;
      use_wdata  = 1'b0;
      upd        = 1'b0;
      head_new   = cur_head_ff;
      cnt_new    = cur_cnt_ff;
      pos        = '0;
      sum        = {1'b0, cur_head_ff} + cur_cnt_ff;
      rsp_in.status     = mpsa_pkg::ST_RANGE;
      rsp_in.slot_out   = cur_ff.slot;
      rsp_in.free_count = '0;
      case (state_ff)
         mpsa_pkg::BK_CLEAR: begin
            clearing = 1'b1;
            ring_we  = 1'b1;
            use_we   = 1'b1;
            clr_in   = clr_ff + AW'(1);
         end
         mpsa_pkg::BK_IDLE: begin
            q_pop = q_valid;
         end
         mpsa_pkg::BK_EXEC: begin
            if (cur_ff.pool_ok) begin
               rsp_in.free_count = cur_cnt_ff;
               case (cur_ff.cmd)
                  mpsa_pkg::CMD_ALLOC: begin
                     if (cur_cnt_ff == '0) begin
                        rsp_in.status   = mpsa_pkg::ST_EMPTY;
                        rsp_in.slot_out = '0;
                     end else begin
                        rsp_in.status   = mpsa_pkg::ST_OK;
                        rsp_in.slot_out = ring_rdata;
                        head_new = ({1'b0, cur_head_ff} + CW'(1) == cur_ff.cap) ?
                                   '0 : cur_head_ff + SW'(1);
                        cnt_new  = cur_cnt_ff - CW'(1);
                        upd      = 1'b1;
                        use_we    = 1'b1;
                        use_waddr = {cidx, ring_rdata[LW-1:0]};
                        use_wdata = 1'b1;
                        rsp_in.free_count = cnt_new;
                     end
                  end
                  mpsa_pkg::CMD_QUERY: begin
                     if (cur_ff.slot_ok) begin
                        rsp_in.status = use_rdata ? mpsa_pkg::ST_OK : mpsa_pkg::ST_NOT_USED;
                     end
                  end
                  mpsa_pkg::CMD_FREE: begin
                     if (cur_ff.slot_ok) begin
                        if (!use_rdata) begin
                           rsp_in.status = mpsa_pkg::ST_NOT_USED;
                        end else begin
                           rsp_in.status = mpsa_pkg::ST_OK;
                           if (cur_ff.to_front) begin
                              head_new = (cur_head_ff == '0) ?
                                         SW'(cur_ff.cap - CW'(1)) : cur_head_ff - SW'(1);
                              pos      = head_new;
                           end else begin
                              pos = (sum >= cur_ff.cap) ? SW'(sum - cur_ff.cap) : SW'(sum);
                           end
                           cnt_new    = cur_cnt_ff + CW'(1);
                           upd        = 1'b1;
                           use_we     = 1'b1;
                           use_waddr  = {cidx, cur_ff.slot[LW-1:0]};
                           use_wdata  = 1'b0;
                           ring_we    = 1'b1;
                           ring_waddr = {cidx, pos[LW-1:0]};
                           ring_wdata = cur_ff.slot;
                           rsp_in.free_count = cnt_new;
                        end
                     end
                  end
                  default: begin
                     rsp_in.status = mpsa_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpsa_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= reinit ? '0 : clr_in;
         rsp_valid_ff <= (state_ff == mpsa_pkg::BK_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (q_pop) begin
         cur_ff      <= q_head;
         cur_head_ff <= head_ff[qidx];
         cur_cnt_ff  <= cnt_ff[qidx];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mpsa_pkg::BK_CLEAR) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            head_ff[p] <= '0;
            cnt_ff[p]  <= mpsa_pkg::cap_of(cfg.pool_capacity, cfg.single_slot_mask[p],
                                           CW'(LIM));
         end
      end else if (upd) begin
         head_ff[cidx] <= head_new;
         cnt_ff[cidx]  <= cnt_new;
      end
   end

   mpsa_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   mpsa_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_use_ram (
      .clock (clock),
      .we    (use_we),
      .waddr (use_waddr),
      .wdata (use_wdata),
      .raddr (use_raddr),
      .rdata (use_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/multi_pool_slot_allocator.sv
// ----------------------------------------------------------------------------
// Multi-pool slot allocator
// Independent fixed-slot pools, each with a circular free list and in-use
// bits, serving allocate, query and free commands.
// ----------------------------------------------------------------------------
//   Channel   Handshake                 Payload
//   request   start in, busy out        req_data  (cmd, pool, slot)
//   result    rsp_valid strobe out      rsp_data  (status, slot_out, free_count)
//   config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// Accepted items wait in a two-entry queue that absorbs bursts. The back end
// takes one item at a time, reading the free list and in-use RAMs in its idle
// state and updating them in its exec state, and registers the result. After
// reset and after each register write a clearing pass rewrites all entries
// (min(NUM_POOLS,16) * 2**ceil(log2(min(slots,256))), 4096 by default) of
// both RAMs, one entry a cycle, with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_pool_slot_allocator #(
   parameter int SLOTS_PER_POOL = 256,
   parameter int NUM_POOLS      = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mpsa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output mpsa_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mpsa_pkg::ADDR_W-1:0]         paddr,
   input  logic [mpsa_pkg::DATA_W-1:0]         pwdata,
   output logic [mpsa_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int LIM       = (SLOTS_PER_POOL < 256) ? SLOTS_PER_POOL : 256;
   localparam int EFF_POOLS = (NUM_POOLS < 16) ? NUM_POOLS : 16;

   logic [mpsa_pkg::COUNT_W-1:0] capacity_ff;
   logic [mpsa_pkg::MASK_W-1:0]  single_ff;
   logic [mpsa_pkg::MASK_W-1:0]  front_ff;
   mpsa_pkg::cfg_type            cfg;
   mpsa_pkg::entry_type          q_head;
   logic [1:0]                   csr_index;
   logic                         csr_write, reinit;
   logic                         push, pop, q_valid, q_full, clearing;

   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;
   assign reinit    = csr_write && (csr_index == mpsa_pkg::CSR_CAPACITY ||
                                    csr_index == mpsa_pkg::CSR_SINGLE_MASK ||
                                    csr_index == mpsa_pkg::CSR_FRONT_MASK);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mpsa_pkg::CAPACITY_RESET;
         single_ff   <= '0;
         front_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            mpsa_pkg::CSR_CAPACITY:    capacity_ff <= pwdata[mpsa_pkg::COUNT_W-1:0];
            mpsa_pkg::CSR_SINGLE_MASK: single_ff   <= pwdata[mpsa_pkg::MASK_W-1:0];
            mpsa_pkg::CSR_FRONT_MASK:  front_ff    <= pwdata[mpsa_pkg::MASK_W-1:0];
            default: begin
               capacity_ff <= capacity_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mpsa_pkg::CSR_CAPACITY:    prdata = mpsa_pkg::DATA_W'(capacity_ff);
         mpsa_pkg::CSR_SINGLE_MASK: prdata = mpsa_pkg::DATA_W'(single_ff);
         mpsa_pkg::CSR_FRONT_MASK:  prdata = mpsa_pkg::DATA_W'(front_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.pool_capacity      = capacity_ff;
   assign cfg.single_slot_mask   = single_ff;
   assign cfg.free_to_front_mask = front_ff;

   assign busy = q_full || clearing;
   assign push = start && !busy;

   mpsa_front #(
      .NUM_POOLS (EFF_POOLS),
      .LIM       (LIM)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .req     (req_data),
      .cfg     (cfg),
      .pop     (pop),
      .q_valid (q_valid),
      .q_full  (q_full),
      .q_head  (q_head)
   );

   mpsa_back #(
      .NUM_POOLS (EFF_POOLS),
      .LIM       (LIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .reinit    (reinit),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/multi_pool_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// Multi-pool slot allocator testbench
// Drives allocate, query, free and unknown-command items into every pool under changing
// capacities and masks, predicts each result with an independent model of
// the free lists and in-use bits, and checks every result field by field.
// ----------------------------------------------------------------------------
module multi_pool_slot_allocator_test;

   import mpsa_pkg::*;

   localparam int POOLS = 16;
   localparam int SLOTS = 256;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef enum bit {
      ROW_ITEM,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         reg_index;
      logic [DATA_W-1:0]  reg_value;
      logic [CMD_W-1:0]   cmd;
      logic [POOL_W-1:0]  pool;
      logic [SLOT_W-1:0]  slot;
      bit                 typed;
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot_out;
      logic [COUNT_W-1:0] free_count;
   } table_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   logic [COUNT_W-1:0] capacity_reg;
   logic [MASK_W-1:0]  single_mask;
   logic [MASK_W-1:0]  front_mask;
   logic [SLOT_W-1:0]  list_slot [POOLS][SLOTS];
   bit                 slot_taken [POOLS][SLOTS];
   int                 list_front [POOLS];
   int                 slots_free [POOLS];

   rsp_type expected_replies [$];
   int      fault_count = 0;
   bit      steady_flow = 1'b0;

   table_row_type directed_rows [$] = '{
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 1, ST_OK, 0, 255},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 15, 0, 1, ST_OK, 0, 255},
      '{ROW_ITEM, 0, 0, CMD_QUERY, 0, 0, 1, ST_OK, 0, 255},
      '{ROW_ITEM, 0, 0, CMD_QUERY, 0, 255, 1, ST_NOT_USED, 255, 255},
      '{ROW_ITEM, 0, 0, CMD_FREE, 0, 255, 1, ST_NOT_USED, 255, 255},
      '{ROW_ITEM, 0, 0, CMD_FREE, 0, 0, 1, ST_OK, 0, 256},
      '{ROW_ITEM, 0, 0, CMD_UNKNOWN, 7, 8'hAA, 1, ST_RANGE, 8'hAA, 256},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_WRITE, CSR_CAPACITY, 32'd2, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_WRITE, CSR_SINGLE_MASK, 32'h8000, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_WRITE, CSR_FRONT_MASK, 32'h0001, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 1, ST_OK, 0, 1},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 1, ST_OK, 1, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 1, ST_EMPTY, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_QUERY, 0, 2, 1, ST_RANGE, 2, 0},
      '{ROW_ITEM, 0, 0, CMD_FREE, 0, 255, 1, ST_RANGE, 255, 0},
      '{ROW_ITEM, 0, 0, CMD_FREE, 0, 1, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_FREE, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 15, 0, 1, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 15, 0, 1, ST_EMPTY, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_FREE, 15, 1, 1, ST_RANGE, 1, 0},
      '{ROW_ITEM, 0, 0, CMD_FREE, 15, 0, 1, ST_OK, 0, 1},
      '{ROW_WRITE, CSR_CAPACITY, 32'd0, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 3, 0, 1, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 3, 0, 1, ST_EMPTY, 0, 0},
      '{ROW_WRITE, CSR_CAPACITY, 32'h1FF, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0},
      '{ROW_ITEM, 0, 0, CMD_ALLOC, 3, 0, 1, ST_OK, 0, 255},
      '{ROW_ITEM, 0, 0, CMD_QUERY, 3, 255, 1, ST_NOT_USED, 255, 255}
   };

   multi_pool_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #12000000;
      $display("multi_pool_slot_allocator_test: errors");
      $finish;
   end

   function automatic int pool_cap(int p);
      int c;
      if (single_mask[p]) begin
         return 1;
      end
      c = int'(capacity_reg);
      if (c < 1) begin
         c = 1;
      end
      if (c > SLOTS) begin
         c = SLOTS;
      end
      return c;
   endfunction

   function automatic void reset_pools();
      int c;
      for (int p = 0; p < POOLS; p++) begin
         c = pool_cap(p);
         for (int s = 0; s < SLOTS; s++) begin
            list_slot[p][s] = (s < c) ? SLOT_W'(s) : '0;
            slot_taken[p][s] = 1'b0;
         end
         list_front[p] = 0;
         slots_free[p] = c;
      end
   endfunction

   function automatic int find_used_slot(int p);
      int c;
      int first;
      c = pool_cap(p);
      first = $urandom_range(0, c - 1);
      for (int k = 0; k < c; k++) begin
         if (slot_taken[p][(first + k) % c]) begin
            return (first + k) % c;
         end
      end
      return -1;
   endfunction

   function automatic rsp_type allocator_outcome(req_type r);
      rsp_type o;
      int      p;
      int      s;
      int      c;
      int      pos;
      p = int'(r.pool);
      s = int'(r.slot);
      c = pool_cap(p);
      o.status = ST_RANGE;
      o.slot_out = r.slot;
      case (r.cmd)
         CMD_ALLOC: begin
            if (slots_free[p] == 0) begin
               o.status = ST_EMPTY;
               o.slot_out = '0;
            end else begin
               o.slot_out = list_slot[p][list_front[p]];
               list_front[p] = (list_front[p] + 1) % c;
               slots_free[p]--;
               slot_taken[p][o.slot_out] = 1'b1;
               o.status = ST_OK;
            end
         end
         CMD_QUERY: begin
            if (s < c) begin
               o.status = slot_taken[p][s] ? ST_OK : ST_NOT_USED;
            end
         end
         CMD_FREE: begin
            if (s < c) begin
               if (!slot_taken[p][s]) begin
                  o.status = ST_NOT_USED;
               end else begin
                  slot_taken[p][s] = 1'b0;
                  if (front_mask[p]) begin
                     list_front[p] = (list_front[p] + c - 1) % c;
                     pos = list_front[p];
                  end else begin
                     pos = (list_front[p] + slots_free[p]) % c;
                  end
                  list_slot[p][pos] = r.slot;
                  slots_free[p]++;
                  o.status = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
      o.free_count = COUNT_W'(slots_free[p]);
      return o;
   endfunction

   // Returns at the falling edge after the item has been accepted.
   task automatic send_item(input req_type item);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic issue_and_predict(input req_type item, input bit typed,
                                    input rsp_type typed_reply);
      rsp_type reply;
      send_item(item);
      reply = allocator_outcome(item);
      expected_replies.push_back(typed ? typed_reply : reply);
   endtask

   task automatic program_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
      start <= 1'b0;
      while (expected_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CSR_CAPACITY:    capacity_reg = value[COUNT_W-1:0];
         CSR_SINGLE_MASK: single_mask = value[MASK_W-1:0];
         CSR_FRONT_MASK:  front_mask = value[MASK_W-1:0];
         default: begin
         end
      endcase
      reset_pools();
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("unexpected result: status %0d slot %0d count %0d",
                        rsp_data.status, rsp_data.slot_out, rsp_data.free_count);
            end
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.status !== want.status || rsp_data.slot_out !== want.slot_out ||
                rsp_data.free_count !== want.free_count) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                           want.status, want.slot_out, want.free_count,
                           rsp_data.status, rsp_data.slot_out, rsp_data.free_count);
               end
            end
         end
      end
   end

   initial begin : stimulus
      table_row_type row;
      req_type       item;
      int            random_sent;
      int            phase_items;
      int            which;
      int            pick;
      int            p;
      int            c;
      int            u;
      logic [DATA_W-1:0] value;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      capacity_reg = CAPACITY_RESET;
      single_mask = '0;
      front_mask = '0;
      reset_pools();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            program_register(row.reg_index, row.reg_value);
         end else begin
            item.cmd = row.cmd;
            item.pool = row.pool;
            item.slot = row.slot;
            issue_and_predict(item, row.typed, {row.status, row.slot_out, row.free_count});
         end
      end

      random_sent = 0;
      while (random_sent < 1830) begin
         which = $urandom_range(1, 7);
         if (which[0]) begin
            case ($urandom_range(0, 7))
               0: value = 0;
               1: value = 1;
               2: value = 256;
               3: value = 511;
               4: value = $urandom_range(0, 511);
               default: value = $urandom_range(2, 12);
            endcase
            program_register(CSR_CAPACITY, value);
         end
         if (which[1]) begin
            case ($urandom_range(0, 3))
               0: value = 0;
               1: value = 32'hFFFF;
               default: value = $urandom() & $urandom();
            endcase
            program_register(CSR_SINGLE_MASK, value);
         end
         if (which[2]) begin
            case ($urandom_range(0, 3))
               0: value = 0;
               1: value = 32'hFFFF;
               default: value = $urandom();
            endcase
            program_register(CSR_FRONT_MASK, value);
         end
         phase_items = $urandom_range(100, 200);
         for (int n = 0; n < phase_items && random_sent < 1830; n++) begin
            if ($urandom_range(0, 39) == 0) begin
               steady_flow = !steady_flow;
            end
            p = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            c = pool_cap(p);
            item.pool = POOL_W'(p);
            item.slot = ($urandom_range(0, 1) == 0) ? SLOT_W'($urandom_range(0, c - 1))
                                                     : SLOT_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
               item.cmd = CMD_ALLOC;
            end else if (pick < 70) begin
               item.cmd = CMD_FREE;
               u = find_used_slot(p);
               if (u >= 0) begin
                  item.slot = SLOT_W'(u);
               end
            end else if (pick < 82) begin
               item.cmd = CMD_QUERY;
               u = find_used_slot(p);
               if (u >= 0) begin
                  item.slot = SLOT_W'(u);
               end
            end else if (pick < 90) begin
               item.cmd = CMD_QUERY;
            end else if (pick < 97) begin
               item.cmd = CMD_FREE;
            end else begin
               item.cmd = CMD_UNKNOWN;
            end
            issue_and_predict(item, 1'b0, '0);
            random_sent++;
         end
      end

      start <= 1'b0;
      while (expected_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("multi_pool_slot_allocator_test: clean");
      end else begin
         $display("multi_pool_slot_allocator_test: errors");
      end
      $finish;
   end

endmodule
